@@ rtl/delx_pkg.sv @@
package delx_pkg;

  // token kinds
  localparam logic [3:0] K_LP    = 4'd0;
  localparam logic [3:0] K_RP    = 4'd1;
  localparam logic [3:0] K_MUL   = 4'd2;
  localparam logic [3:0] K_DIV   = 4'd3;
  localparam logic [3:0] K_ADD   = 4'd4;
  localparam logic [3:0] K_SUB   = 4'd5;
  localparam logic [3:0] K_EQ    = 4'd6;
  localparam logic [3:0] K_NEQ   = 4'd7;
  localparam logic [3:0] K_HEX   = 4'd8;
  localparam logic [3:0] K_DEC   = 4'd9;
  localparam logic [3:0] K_REG   = 4'd10;
  localparam logic [3:0] K_DEREF = 4'd11;
  localparam logic [3:0] K_AND   = 4'd12;
  localparam logic [3:0] K_END   = 4'd13;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMATCH  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_EQ1  = 4'd1,
    M_NE1  = 4'd2,
    M_AND1 = 4'd3,
    M_ZERO = 4'd4,
    M_HEXP = 4'd5,
    M_HEX  = 4'd6,
    M_DEC  = 4'd7,
    M_REG0 = 4'd8,
    M_REGL = 4'd9,
    M_REGD = 4'd10
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [1:0]  status;
    logic        fin;
  } res_t;

  // push side of the result queue
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      data;
  } oq_push_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_let(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // saturate a position or length to the 16-bit result field
  function automatic logic [15:0] clip16(input logic [32:0] v);
    return (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

@@ rtl/delx_outq.sv @@
module delx_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  delx_pkg::oq_push_t push,
  output logic [2:0]         free,
  output logic               out_valid,
  input  logic               out_stall,
  output delx_pkg::res_t     head
);
  import delx_pkg::*;

  res_t              mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign free      = OQ_CW'(OQ_DEPTH) - cnt_r;

  assign wr_ptr_nxt = wr_ptr_r + OQ_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
  assign cnt_nxt    = cnt_r + OQ_CW'(push.cnt) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.data[0];
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + OQ_AW'(1)] <= push.data[1];
    end
  end

endmodule

@@ rtl/debug_expression_lexer_unit.sv @@
// Streaming expression lexer: one character beat in, token beats out.
// A token leaves once the beat that completes it has passed the input register
// and the lexer step has written it into the result queue.
// Throughput: one character per cycle; the step needs room for two results
// in the four-entry result queue, so the output side paces a stalled stream.
// Reset (synchronous, active low) empties the queue and returns the lexer idle.
module debug_expression_lexer_unit #(
  parameter int MAX_TOKENS = 65536,
  parameter int POS_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_start_pos,
  output logic [15:0] out_token_len,
  output logic [1:0]  out_status,
  output logic        out_final_flag
);
  import delx_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_TOKENS);

  // lexer state carried from one character to the next
  typedef struct packed {
    mode_t               mode;
    logic [POS_BITS-1:0] tstart;
    logic [POS_BITS-1:0] cpos;
    logic [CNT_W-1:0]    tcnt;
    logic [3:0]          pkind;
    logic                skip;
  } lex_st_t;

  localparam lex_st_t ST_RESET = '{mode: M_IDLE, tstart: '0, cpos: '0, tcnt: '0,
                                   pkind: '0, skip: 1'b0};

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  // append one result to the pair built for this beat
  function automatic void put_res(inout res_t [1:0] q, inout logic [1:0] n,
                                  input logic [3:0] kind, input logic [POS_BITS-1:0] start,
                                  input logic [POS_BITS:0] len, input logic [1:0] status,
                                  input logic fin);
    res_t r;
    r.kind   = kind;
    r.start  = clip16(33'(start));
    r.len    = clip16(33'(len));
    r.status = status;
    r.fin    = fin;
    q[n[0]]  = r;
    n        = n + 2'd1;
  endfunction

  // error result; a NUL ends the string at once, otherwise drop until NUL
  function automatic void err_f(inout lex_st_t s, inout res_t [1:0] q,
                                inout logic [1:0] n, input logic [1:0] status,
                                input logic [POS_BITS-1:0] where, input logic [7:0] c);
    put_res(q, n, K_LP, where, '0, status, 1'b1);
    if (c == CH_NUL) begin
      s = ST_RESET;
    end else begin
      s.mode = M_IDLE;
      s.skip = 1'b1;
    end
  endfunction

  // token result; returns 0 when the token limit turned it into an error
  function automatic logic emit_f(inout lex_st_t s, inout res_t [1:0] q,
                                  inout logic [1:0] n, input logic [3:0] kind,
                                  input logic [POS_BITS-1:0] start,
                                  input logic [POS_BITS:0] len, input logic [7:0] c);
    logic [3:0] k;
    logic       ok;
    k  = kind;
    ok = 1'b0;
    if (s.tcnt == CNT_MAX) begin
      err_f(s, q, n, ST_OVERFLOW, start, c);
    end else begin
      // a star in operand position is a dereference
      if (k == K_MUL) begin
        if ((s.tcnt == '0) || (s.pkind inside {K_LP, K_ADD, K_SUB, K_MUL, K_DIV,
                                               K_EQ, K_NEQ, K_AND})) begin
          k = K_DEREF;
        end
      end
      put_res(q, n, k, start, len, ST_OK, 1'b0);
      s.tcnt  = s.tcnt + CNT_W'(1);
      s.pkind = k;
      s.mode  = M_IDLE;
      ok      = 1'b1;
    end
    return ok;
  endfunction

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       proc;
  logic [2:0] oq_free;

  lex_st_t    st_r, st_nxt;
  oq_push_t   push;
  res_t       head;

  // process the held character only when the queue can take both results
  assign proc     = in_v_r && (oq_free >= 3'd2);
  assign in_stall = in_v_r && !proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= ST_RESET;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (proc) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_char_r <= in_char_code;
    end
  end

  // one lexer step per character
  always_comb begin
    lex_st_t             s;
    res_t [1:0]          q;
    logic [1:0]          n;
    logic [7:0]          c;
    logic [POS_BITS-1:0] pos;
    logic [3:0]          fk;
    logic                fl;
    logic                stop;
    logic [7:0]          want;
    logic [3:0]          pk;

    s    = st_r;
    q    = '0;
    n    = 2'd0;
    c    = in_char_r;
    pos  = st_r.cpos;
    fk   = K_LP;
    fl   = 1'b0;
    stop = 1'b0;
    want = (st_r.mode == M_AND1) ? CH_AMP : CH_EQ;
    pk   = (st_r.mode == M_EQ1) ? K_EQ : (st_r.mode == M_NE1) ? K_NEQ : K_AND;

    if (s.skip) begin
      // drop everything up to the terminating NUL
      if (c == CH_NUL) begin
        s = ST_RESET;
      end
      stop = 1'b1;
    end else begin
      unique case (s.mode)
        M_EQ1, M_NE1, M_AND1: begin
          if (c == want) begin
            if (emit_f(s, q, n, pk, s.tstart,
                       {1'b0, pos} + (POS_BITS+1)'(1) - {1'b0, s.tstart}, c)) begin
              s.cpos = sat_inc(pos);
            end
          end else begin
            err_f(s, q, n, ST_NOMATCH, s.tstart, c);
          end
          stop = 1'b1;
        end
        M_ZERO: begin
          if ((c == CH_LX) || (c == CH_UX)) begin
            s.mode = M_HEXP;
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else if (is_dig(c)) begin
            s.mode = M_DEC;
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else begin
            fk = K_DEC;
            fl = 1'b1;
          end
        end
        M_HEXP: begin
          if (is_hex(c)) begin
            s.mode = M_HEX;
            s.cpos = sat_inc(pos);
          end else if (emit_f(s, q, n, K_DEC, s.tstart, (POS_BITS+1)'(1), c)) begin
            // the lone 0 stands; the x after it matches nothing
            err_f(s, q, n, ST_NOMATCH, sat_inc(s.tstart), c);
          end
          stop = 1'b1;
        end
        M_HEX: begin
          if (is_hex(c)) begin
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else begin
            fk = K_HEX;
            fl = 1'b1;
          end
        end
        M_DEC: begin
          if (is_dig(c)) begin
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else begin
            fk = K_DEC;
            fl = 1'b1;
          end
        end
        M_REG0: begin
          if (is_let(c)) begin
            s.mode = M_REGL;
            s.cpos = sat_inc(pos);
          end else begin
            err_f(s, q, n, ST_NOMATCH, s.tstart, c);
          end
          stop = 1'b1;
        end
        M_REGL: begin
          if (is_let(c)) begin
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else if (is_dig(c)) begin
            s.mode = M_REGD;
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else begin
            fk = K_REG;
            fl = 1'b1;
          end
        end
        M_REGD: begin
          if (is_dig(c)) begin
            s.cpos = sat_inc(pos);
            stop   = 1'b1;
          end else begin
            fk = K_REG;
            fl = 1'b1;
          end
        end
        default: begin
          s.mode = M_IDLE;
        end
      endcase

      // close the pending number or register
      if (!stop && fl) begin
        if (!emit_f(s, q, n, fk, s.tstart, {1'b0, pos} - {1'b0, s.tstart}, c)) begin
          stop = 1'b1;
        end
      end

      // start of a new token at this character
      if (!stop) begin
        case (c)
          CH_NUL: begin
            put_res(q, n, K_END, pos, '0, ST_OK, 1'b1);
            s    = ST_RESET;
            stop = 1'b1;
          end
          CH_SPACE: ;
          CH_LP:    stop = !emit_f(s, q, n, K_LP, pos, (POS_BITS+1)'(1), c);
          CH_RP:    stop = !emit_f(s, q, n, K_RP, pos, (POS_BITS+1)'(1), c);
          CH_STAR:  stop = !emit_f(s, q, n, K_MUL, pos, (POS_BITS+1)'(1), c);
          CH_SLASH: stop = !emit_f(s, q, n, K_DIV, pos, (POS_BITS+1)'(1), c);
          CH_PLUS:  stop = !emit_f(s, q, n, K_ADD, pos, (POS_BITS+1)'(1), c);
          CH_MINUS: stop = !emit_f(s, q, n, K_SUB, pos, (POS_BITS+1)'(1), c);
          CH_EQ: begin
            s.mode   = M_EQ1;
            s.tstart = pos;
          end
          CH_BANG: begin
            s.mode   = M_NE1;
            s.tstart = pos;
          end
          CH_AMP: begin
            s.mode   = M_AND1;
            s.tstart = pos;
          end
          CH_DOLLAR: begin
            s.mode   = M_REG0;
            s.tstart = pos;
          end
          CH_ZERO: begin
            s.mode   = M_ZERO;
            s.tstart = pos;
          end
          default: begin
            if (is_dig(c)) begin
              s.mode   = M_DEC;
              s.tstart = pos;
            end else begin
              err_f(s, q, n, ST_NOMATCH, pos, c);
              stop = 1'b1;
            end
          end
        endcase
        if (!stop) begin
          s.cpos = sat_inc(pos);
        end
      end
    end

    st_nxt    = s;
    push.data = q;
    push.cnt  = proc ? n : 2'd0;
  end

  delx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (oq_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind = head.kind;
  assign out_start_pos  = head.start;
  assign out_token_len  = head.len;
  assign out_status     = head.status;
  assign out_final_flag = head.fin;

endmodule
